@@ rtl/cti_pkg.sv @@
package cti_pkg;

  localparam int ETA_W       = 14;
  localparam int PHI_W       = 13;
  localparam int EN_W        = 16;
  localparam int COUNT_W     = 13;
  localparam int SUM_W       = 28;
  localparam int DIST_W      = 29;
  localparam int DIST_OUT_W  = 28;
  localparam int RADIUS_W    = 30;
  localparam int VALUE_W     = 29;
  localparam int KIND_W      = 5;
  localparam int NUM_E_CUTS  = 9;
  localparam int NUM_ET_CUTS = 5;
  localparam int NUM_COUNTS  = NUM_E_CUTS + NUM_ET_CUTS;
  localparam int NUM_WORDS   = 24;

  // Towers beyond this many in one event are not accumulated.
  localparam int MAX_TOWERS = 4096;

  localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
  localparam logic [SUM_W-1:0]      SUM_MAX      = '1;
  localparam logic [DIST_OUT_W-1:0] DIST_OUT_MAX = '1;
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET = 30'd94372;

  localparam logic [PHI_W-1:0]      PI_FIX     = 13'd3217;
  localparam logic signed [13:0]    TWO_PI_FIX = 14'sd6434;

  // Summary word codes.
  localparam logic [KIND_W-1:0] KIND_TOWERS    = 5'd14;
  localparam logic [KIND_W-1:0] KIND_SUM       = 5'd15;
  localparam logic [KIND_W-1:0] KIND_MAX_E     = 5'd16;
  localparam logic [KIND_W-1:0] KIND_MAX_ET    = 5'd20;
  localparam logic [KIND_W-1:0] KIND_LAST      = 5'd23;

  localparam logic [EN_W-1:0] E_CUT [NUM_E_CUTS] = '{
    16'd10, 16'd20, 16'd30, 16'd40, 16'd50, 16'd60, 16'd70, 16'd80, 16'd90
  };
  localparam logic [EN_W-1:0] ET_CUT [NUM_ET_CUTS] = '{
    16'd1, 16'd2, 16'd5, 16'd10, 16'd20
  };

  typedef struct packed {
    logic                    valid;
    logic [EN_W-1:0]         quantity;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    logic [DIST_OUT_W-1:0]   distance;
  } record_t;

  // Squared eta-phi distance with a single phi wrap step.
  function automatic logic [DIST_W-1:0] dist_sq(
    input logic signed [ETA_W-1:0] eta,
    input logic signed [PHI_W-1:0] phi,
    input logic signed [ETA_W-1:0] ref_eta,
    input logic signed [PHI_W-1:0] ref_phi
  );
    logic signed [ETA_W:0]   de;
    logic signed [PHI_W:0]   dp;
    logic signed [PHI_W:0]   dp_neg;
    logic [PHI_W-1:0]        dp_abs;
    logic signed [PHI_W:0]   dp_w;
    logic signed [2*ETA_W+1:0] de_sq;
    logic signed [2*PHI_W+1:0] dp_sq;
    de     = {eta[ETA_W-1], eta} - {ref_eta[ETA_W-1], ref_eta};
    dp     = {phi[PHI_W-1], phi} - {ref_phi[PHI_W-1], ref_phi};
    dp_neg = -dp;
    dp_abs = dp[PHI_W] ? dp_neg[PHI_W-1:0] : dp[PHI_W-1:0];
    if (dp_abs > PI_FIX) begin
      dp_w = TWO_PI_FIX - $signed({1'b0, dp_abs});
    end else begin
      dp_w = $signed({1'b0, dp_abs});
    end
    de_sq = de * de;
    dp_sq = dp_w * dp_w;
    return de_sq[DIST_W-1:0] + {1'b0, dp_sq[2*PHI_W+1:0]};
  endfunction

endpackage

@@ rtl/calo_tower_isolation_counter_unit.sv @@
// Channel   Dir  tdata / tuser / tlast
// s_axis    in   tdata: eta, phi, energy, transverse_energy; tuser: mode, electron_select;
//                tlast: last_tower
// m_axis    out  tdata: value; tuser: kind; tlast: last_word
// cfg       in   cfg_we, cfg_wdata: iso_radius_sq
//
// One input word is taken every cycle unless a tower waits on a held accumulate stage; a tower
// passes an input register, a distance stage and an accumulate stage before the summary starts.
// The 24 summary words leave from a snapshot shift line, one per cycle that m_axis_tready
// allows; a further last tower waits in the accumulate stage until the snapshot is free.
// Reset is synchronous, clears the accumulators and electron positions and sets the
// radius to its default.
module calo_tower_isolation_counter_unit #(
  parameter int MAX_TOWERS = cti_pkg::MAX_TOWERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // eta[13:0], phi[26:14], energy[42:27],
                                     // transverse_energy[58:43], zero fill
  input  logic [1:0]  s_axis_tuser,  // mode[0], electron_select[1]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // value[28:0], zero fill
  output logic [4:0]  m_axis_tuser,  // kind[4:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata
);

  localparam int ETA_W   = cti_pkg::ETA_W;
  localparam int PHI_W   = cti_pkg::PHI_W;
  localparam int EN_W    = cti_pkg::EN_W;
  localparam int COUNT_W = cti_pkg::COUNT_W;
  localparam int SUM_W   = cti_pkg::SUM_W;
  localparam int DIST_W  = cti_pkg::DIST_W;
  localparam int VALUE_W = cti_pkg::VALUE_W;
  localparam int KIND_W  = cti_pkg::KIND_W;
  localparam int NWORDS  = cti_pkg::NUM_WORDS;
  localparam int NCOUNT  = cti_pkg::NUM_COUNTS;
  localparam int NECUT   = cti_pkg::NUM_E_CUTS;
  localparam int NETCUT  = cti_pkg::NUM_ET_CUTS;

  logic [cti_pkg::RADIUS_W-1:0] iso_radius_sq;
  logic signed [ETA_W-1:0] electron_eta [2];
  logic signed [PHI_W-1:0] electron_phi [2];

  // Input register.
  logic                    s1_valid;
  logic                    s1_mode;
  logic                    s1_sel;
  logic signed [ETA_W-1:0] s1_eta;
  logic signed [PHI_W-1:0] s1_phi;
  logic [EN_W-1:0]         s1_e;
  logic [EN_W-1:0]         s1_et;
  logic                    s1_last;

  // Accumulate stage register.
  logic                    s2_valid;
  logic signed [ETA_W-1:0] s2_eta;
  logic signed [PHI_W-1:0] s2_phi;
  logic [EN_W-1:0]         s2_e;
  logic [EN_W-1:0]         s2_et;
  logic                    s2_last;
  logic [DIST_W-1:0]       s2_dist;

  // Event accumulators.
  logic [COUNT_W-1:0] threshold_counts [NCOUNT];
  logic [COUNT_W-1:0] tower_count;
  logic [SUM_W-1:0]   energy_sum;
  cti_pkg::record_t   max_energy_record;
  cti_pkg::record_t   max_et_record;

  // Summary snapshot and emission.
  logic [VALUE_W-1:0] snap [NWORDS];
  logic               snap_busy;
  logic [KIND_W-1:0]  emit_index;

  logic adv1, adv2, s2_free, emit;
  logic [DIST_W-1:0] d0, d1, s1_dist;

  logic               tower_taken, extra;
  logic [cti_pkg::DIST_OUT_W-1:0] dist_sat;
  logic [COUNT_W-1:0] counts_next [NCOUNT];
  logic [COUNT_W-1:0] tower_count_next;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   energy_sum_next;
  cti_pkg::record_t   max_energy_record_next;
  cti_pkg::record_t   max_et_record_next;
  logic [VALUE_W-1:0] snap_next [NWORDS];

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c != cti_pkg::COUNT_MAX) ? c + 1'b1 : c;
  endfunction

  function automatic cti_pkg::record_t take_record(
    input cti_pkg::record_t                r,
    input logic [EN_W-1:0]                 q,
    input logic signed [ETA_W-1:0]         eta,
    input logic signed [PHI_W-1:0]         phi,
    input logic [cti_pkg::DIST_OUT_W-1:0]  d
  );
    cti_pkg::record_t n;
    n = r;
    if (!r.valid || q > r.quantity) begin
      n.valid    = 1'b1;
      n.quantity = q;
      n.eta      = eta;
      n.phi      = phi;
      n.distance = d;
    end
    return n;
  endfunction

  function automatic logic [VALUE_W-1:0] record_word(
    input cti_pkg::record_t r,
    input logic [1:0]       part
  );
    logic [VALUE_W-1:0] w;
    case (part)
      2'd0:    w = VALUE_W'(r.quantity);
      2'd1:    w = {{(VALUE_W-ETA_W){r.eta[ETA_W-1]}}, r.eta};
      2'd2:    w = {{(VALUE_W-PHI_W){r.phi[PHI_W-1]}}, r.phi};
      default: w = VALUE_W'(r.distance);
    endcase
    return r.valid ? w : '0;
  endfunction

  // Handshake and stage advance.
  assign adv2          = s2_valid && !(s2_last && snap_busy);
  assign s2_free       = !s2_valid || adv2;
  assign adv1          = s1_valid && (!s1_mode || s2_free);
  assign s_axis_tready = !s1_valid || adv1;
  assign emit          = snap_busy && (!m_axis_tvalid || m_axis_tready);

  // Distance stage.
  always_comb begin
    d0      = cti_pkg::dist_sq(s1_eta, s1_phi, electron_eta[0], electron_phi[0]);
    d1      = cti_pkg::dist_sq(s1_eta, s1_phi, electron_eta[1], electron_phi[1]);
    s1_dist = (d0 < d1) ? d0 : d1;
  end

  // Accumulate stage.
  always_comb begin
    tower_taken = 32'(tower_count) < 32'(MAX_TOWERS);
    extra       = {1'b0, s2_dist} > iso_radius_sq;
    dist_sat    = (s2_dist > DIST_W'(cti_pkg::DIST_OUT_MAX)) ? cti_pkg::DIST_OUT_MAX
                                                           : s2_dist[cti_pkg::DIST_OUT_W-1:0];
    sum_wide    = {1'b0, energy_sum} + (SUM_W+1)'(s2_e);

    counts_next            = threshold_counts;
    tower_count_next       = tower_count;
    energy_sum_next        = energy_sum;
    max_energy_record_next = max_energy_record;
    max_et_record_next     = max_et_record;

    if (tower_taken) begin
      tower_count_next = bump(tower_count);
      energy_sum_next  = (sum_wide > {1'b0, cti_pkg::SUM_MAX}) ? cti_pkg::SUM_MAX
                                                               : sum_wide[SUM_W-1:0];
      max_energy_record_next = take_record(max_energy_record, s2_e, s2_eta, s2_phi, dist_sat);
      max_et_record_next     = take_record(max_et_record, s2_et, s2_eta, s2_phi, dist_sat);
      if (extra) begin
        for (int i = 0; i < NECUT; i++) begin
          if (s2_e > cti_pkg::E_CUT[i]) begin
            counts_next[i] = bump(threshold_counts[i]);
          end
        end
        for (int i = 0; i < NETCUT; i++) begin
          if (s2_et > cti_pkg::ET_CUT[i]) begin
            counts_next[NECUT+i] = bump(threshold_counts[NECUT+i]);
          end
        end
      end
    end

    // Summary words as they stand after this tower.
    for (int i = 0; i < NCOUNT; i++) begin
      snap_next[i] = VALUE_W'(counts_next[i]);
    end
    snap_next[cti_pkg::KIND_TOWERS] = VALUE_W'(tower_count_next);
    snap_next[cti_pkg::KIND_SUM]    = VALUE_W'(energy_sum_next);
    for (int i = 0; i < 4; i++) begin
      snap_next[int'(cti_pkg::KIND_MAX_E) + i]  = record_word(max_energy_record_next, 2'(i));
      snap_next[int'(cti_pkg::KIND_MAX_ET) + i] = record_word(max_et_record_next, 2'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iso_radius_sq     <= cti_pkg::RADIUS_RESET;
      electron_eta[0]   <= '0;
      electron_eta[1]   <= '0;
      electron_phi[0]   <= '0;
      electron_phi[1]   <= '0;
      s1_valid          <= 1'b0;
      s2_valid          <= 1'b0;
      for (int i = 0; i < NCOUNT; i++) begin
        threshold_counts[i] <= '0;
      end
      tower_count       <= '0;
      energy_sum        <= '0;
      max_energy_record <= '0;
      max_et_record     <= '0;
      snap_busy         <= 1'b0;
      emit_index        <= '0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        iso_radius_sq <= cfg_wdata;
      end

      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
        s1_mode  <= s_axis_tuser[0];
        s1_sel   <= s_axis_tuser[1];
        s1_eta   <= s_axis_tdata[13:0];
        s1_phi   <= s_axis_tdata[26:14];
        s1_e     <= s_axis_tdata[42:27];
        s1_et    <= s_axis_tdata[58:43];
        s1_last  <= s_axis_tlast;
      end

      // An electron load ends in the input stage.
      if (adv1 && !s1_mode) begin
        electron_eta[s1_sel] <= s1_eta;
        electron_phi[s1_sel] <= s1_phi;
      end

      if (s2_free) begin
        s2_valid <= adv1 && s1_mode;
        s2_eta   <= s1_eta;
        s2_phi   <= s1_phi;
        s2_e     <= s1_e;
        s2_et    <= s1_et;
        s2_last  <= s1_last;
        s2_dist  <= s1_dist;
      end

      if (adv2) begin
        if (s2_last) begin
          for (int i = 0; i < NCOUNT; i++) begin
            threshold_counts[i] <= '0;
          end
          tower_count       <= '0;
          energy_sum        <= '0;
          max_energy_record <= '0;
          max_et_record     <= '0;
          snap_busy         <= 1'b1;
        end else begin
          threshold_counts  <= counts_next;
          tower_count       <= tower_count_next;
          energy_sum        <= energy_sum_next;
          max_energy_record <= max_energy_record_next;
          max_et_record     <= max_et_record_next;
        end
      end

      if (emit) begin
        m_axis_tvalid <= 1'b1;
        if (emit_index == cti_pkg::KIND_LAST) begin
          emit_index <= '0;
          snap_busy  <= 1'b0;
        end else begin
          emit_index <= emit_index + 1'b1;
        end
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Snapshot shift line and output payload.
  always_ff @(posedge clk) begin
    if (adv2 && s2_last) begin
      snap <= snap_next;
    end else if (emit) begin
      for (int i = 0; i < NWORDS - 1; i++) begin
        snap[i] <= snap[i+1];
      end
    end
    if (emit) begin
      m_axis_tdata <= {(32-VALUE_W)'(0), snap[0]};
      m_axis_tuser <= emit_index;
      m_axis_tlast <= (emit_index == cti_pkg::KIND_LAST);
    end
  end

endmodule
